// ----- sv/sstt_pkg.sv -----
// ----------------------------------------------------------------------------
// sstt_pkg: shared types and constants of the sparse triplet table
// Request and result transfer types, status codes, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package sstt_pkg;

  // Field widths
  localparam int unsigned IDX_W = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 8;

  // Limit registers after reset
  localparam logic [IDX_W-1:0] ROW_LIMIT_RST = 16'd100;
  localparam logic [IDX_W-1:0] COL_LIMIT_RST = 16'd100;

  // Register map (byte address bit 2 selects the register)
  localparam logic REG_ROW_LIMIT = 1'b0;
  localparam logic REG_COL_LIMIT = 1'b1;

  // Request kinds
  localparam logic REQ_SET = 1'b0;
  localparam logic REQ_GET = 1'b1;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_RANGE    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  // Input transfer
  typedef struct packed {
    logic                     req_type;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [VAL_W-1:0]  write_value;
  } req_t;

  // Result transfer
  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  read_value;
    logic [CNT_W-1:0]         entry_count;
  } rsp_t;

  // Classified request held in the queue
  typedef struct packed {
    req_t req;
    logic oor;   // coordinate zero or outside the configured size
  } qent_t;

  // Queue handshake from front to queue
  typedef struct packed {
    logic  push;
    qent_t ent;
  } qpush_t;

  // Queue head towards the back end
  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qhead_t;

  // Back-end state machine
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_DRAIN,
    S_INSERT,
    S_DONE
  } bstate_t;

endpackage : sstt_pkg

`default_nettype wire

// ----- sv/sstt_front.sv -----
// ----------------------------------------------------------------------------
// sstt_front: request intake and classification
// Holds the limit registers behind the APB port and flags requests whose
// coordinates are zero or fall outside the configured matrix size.
// ----------------------------------------------------------------------------
`default_nettype none

module sstt_front (
  input  wire                  clk,
  input  wire                  rst,
  // APB-style configuration port
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [2:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // request channel
  input  wire                  in_valid,
  output logic                 in_stall,
  input  sstt_pkg::req_t       in_data,
  // towards the queue
  input  wire                  q_full,
  output sstt_pkg::qpush_t     qpush
);

  logic [sstt_pkg::IDX_W-1:0] row_limit;
  logic [sstt_pkg::IDX_W-1:0] col_limit;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit <= sstt_pkg::ROW_LIMIT_RST;
      col_limit <= sstt_pkg::COL_LIMIT_RST;
    end else if (wr_en) begin
      if (paddr[2] == sstt_pkg::REG_ROW_LIMIT) begin
        row_limit <= pwdata[sstt_pkg::IDX_W-1:0];
      end else begin
        col_limit <= pwdata[sstt_pkg::IDX_W-1:0];
      end
    end
  end

  // read-back
  always_comb begin
    if (paddr[2] == sstt_pkg::REG_ROW_LIMIT) begin
      prdata = {16'd0, row_limit};
    end else begin
      prdata = {16'd0, col_limit};
    end
  end

  // accept while the queue has room; classify on the way in
  assign in_stall = q_full;

  always_comb begin
    qpush.push    = in_valid & ~q_full;
    qpush.ent.req = in_data;
    qpush.ent.oor = (in_data.row_index == '0) || (in_data.row_index > row_limit) ||
                    (in_data.col_index == '0) || (in_data.col_index > col_limit);
  end

endmodule : sstt_front

`default_nettype wire

// ----- sv/sstt_queue.sv -----
// ----------------------------------------------------------------------------
// sstt_queue: two-entry request queue
// Decouples request intake from the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sstt_queue (
  input  wire               clk,
  input  wire               rst,
  input  sstt_pkg::qpush_t  qpush,
  output logic              full,
  input  wire               pop,
  output sstt_pkg::qhead_t  head
);

  sstt_pkg::qent_t slots [2];
  logic            wp;
  logic            rp;
  logic [1:0]      fill;
  logic            do_pop;

  assign full   = (fill == 2'd2);
  assign do_pop = pop & (fill != 2'd0);

  // payload storage
  always_ff @(posedge clk) begin
    if (qpush.push) begin
      slots[wp] <= qpush.ent;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (qpush.push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      case ({qpush.push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_comb begin
    head.valid = (fill != 2'd0);
    head.ent   = slots[rp];
  end

endmodule : sstt_queue

`default_nettype wire

// ----- sv/sstt_back.sv -----
// ----------------------------------------------------------------------------
// sstt_back: triplet table engine
// Scans the ordered table back from its last entry, then overwrites,
// removes (shifting later entries down) or inserts (shifting them up).
// One memory port pair: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sstt_back #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire               clk,
  input  wire               rst,
  input  sstt_pkg::qhead_t  head,
  output logic              pop,
  output logic              out_valid,
  input  wire               out_stall,
  output sstt_pkg::rsp_t    out_data
);

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned EW  = 2 * sstt_pkg::IDX_W + sstt_pkg::VAL_W;
  localparam int unsigned KW  = 2 * sstt_pkg::IDX_W;

  // table memory: {row, col, value} per entry
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;

  sstt_pkg::bstate_t state, state_next;

  // request held for the duration of the operation
  sstt_pkg::req_t    req;
  logic              req_oor;

  logic [CW-1:0]     count;
  logic [AW-1:0]     j;          // scan position
  logic              none;       // no entry at or below the key
  logic              match;
  logic [sstt_pkg::VAL_W-1:0] hit_value;
  logic [AW-1:0]     slot;
  logic [AW-1:0]     src;
  logic [AW-1:0]     last;
  logic              up;         // shift towards higher slots (insert)
  logic              pend;
  logic [AW-1:0]     pend_src;
  sstt_pkg::status_t res_status;
  logic [sstt_pkg::VAL_W-1:0] res_value;

  // helpers
  logic [KW-1:0]     key;
  logic [KW-1:0]     ent_key;
  logic              key_less;
  logic              v_zero;
  logic              is_get;
  logic              tbl_full;
  logic [CW-1:0]     jp1;
  logic [CW-1:0]     slot_calc;
  logic [CW-1:0]     cnt_m1;
  logic [CW+7:0]     cnt_ext;
  logic              out_free;

  assign key       = {req.row_index, req.col_index};
  assign ent_key   = rdata[EW-1:sstt_pkg::VAL_W];
  assign key_less  = key < ent_key;
  assign v_zero    = (req.write_value == '0);
  assign is_get    = (req.req_type == sstt_pkg::REQ_GET);
  assign tbl_full  = (count >= CW'(CAPACITY));
  assign jp1       = {{(CW-AW){1'b0}}, j} + CW'(1);
  assign slot_calc = none ? '0 : jp1;
  assign cnt_m1    = count - CW'(1);
  assign cnt_ext   = {8'd0, count};
  assign out_free  = ~out_valid | ~out_stall;

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sstt_pkg::S_IDLE: begin
        if (head.valid) begin
          if (head.ent.oor) begin
            state_next = sstt_pkg::S_DONE;
          end else if (count == '0) begin
            state_next = sstt_pkg::S_DECIDE;
          end else begin
            state_next = sstt_pkg::S_SCAN;
          end
        end
      end
      sstt_pkg::S_SCAN: begin
        if (!key_less || j == '0) begin
          state_next = sstt_pkg::S_DECIDE;
        end
      end
      sstt_pkg::S_DECIDE: begin
        if (is_get) begin
          state_next = sstt_pkg::S_DONE;
        end else if (match) begin
          if (v_zero && jp1 != count) begin
            state_next = sstt_pkg::S_SHIFT;
          end else begin
            state_next = sstt_pkg::S_DONE;
          end
        end else if (v_zero || tbl_full) begin
          state_next = sstt_pkg::S_DONE;
        end else if (slot_calc == count) begin
          state_next = sstt_pkg::S_INSERT;
        end else begin
          state_next = sstt_pkg::S_SHIFT;
        end
      end
      sstt_pkg::S_SHIFT: begin
        if (src == last) begin
          state_next = sstt_pkg::S_DRAIN;
        end
      end
      sstt_pkg::S_DRAIN: begin
        state_next = up ? sstt_pkg::S_INSERT : sstt_pkg::S_DONE;
      end
      sstt_pkg::S_INSERT: begin
        state_next = sstt_pkg::S_DONE;
      end
      sstt_pkg::S_DONE: begin
        if (out_free) begin
          state_next = sstt_pkg::S_IDLE;
        end
      end
      default: state_next = sstt_pkg::S_IDLE;
    endcase
  end

  // memory and queue controls
  always_comb begin
    pop   = 1'b0;
    raddr = src;
    we    = 1'b0;
    waddr = j;
    wdata = {req.row_index, req.col_index, req.write_value};
    case (state)
      sstt_pkg::S_IDLE: begin
        pop   = head.valid;
        raddr = cnt_m1[AW-1:0];
      end
      sstt_pkg::S_SCAN: begin
        raddr = j - AW'(1);
      end
      sstt_pkg::S_DECIDE: begin
        // overwrite on a match with a nonzero value
        we = ~is_get & match & ~v_zero;
      end
      sstt_pkg::S_INSERT: begin
        we    = 1'b1;
        waddr = slot;
      end
      default: begin
      end
    endcase
    // pending shift move: data read last cycle goes one slot over
    if (pend) begin
      we    = 1'b1;
      waddr = up ? (pend_src + AW'(1)) : (pend_src - AW'(1));
      wdata = rdata;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sstt_pkg::S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == sstt_pkg::S_SHIFT);
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        sstt_pkg::S_DECIDE: begin
          if (!is_get && match && v_zero && jp1 == count) begin
            count <= cnt_m1;
          end
        end
        sstt_pkg::S_DRAIN: begin
          if (!up) begin
            count <= cnt_m1;
          end
        end
        sstt_pkg::S_INSERT: begin
          count <= count + CW'(1);
        end
        sstt_pkg::S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pend_src <= src;
    case (state)
      sstt_pkg::S_IDLE: begin
        req        <= head.ent.req;
        req_oor    <= head.ent.oor;
        j          <= cnt_m1[AW-1:0];
        none       <= (count == '0);
        match      <= 1'b0;
        res_status <= sstt_pkg::ST_RANGE;
        res_value  <= '0;
      end
      sstt_pkg::S_SCAN: begin
        if (key_less) begin
          if (j == '0) begin
            none <= 1'b1;
          end else begin
            j <= j - AW'(1);
          end
        end else begin
          match     <= (key == ent_key);
          hit_value <= rdata[sstt_pkg::VAL_W-1:0];
        end
      end
      sstt_pkg::S_DECIDE: begin
        res_status <= sstt_pkg::ST_OK;
        slot       <= slot_calc[AW-1:0];
        if (is_get) begin
          if (match) begin
            res_value <= hit_value;
          end else begin
            res_status <= sstt_pkg::ST_NOTFOUND;
          end
        end else if (match) begin
          // remove: move entries above the match down one slot
          src  <= jp1[AW-1:0];
          last <= cnt_m1[AW-1:0];
          up   <= 1'b0;
        end else if (v_zero) begin
          res_status <= sstt_pkg::ST_NOTFOUND;
        end else if (tbl_full) begin
          res_status <= sstt_pkg::ST_FULL;
        end else begin
          // insert: move entries from the top down to the slot up one
          src  <= cnt_m1[AW-1:0];
          last <= slot_calc[AW-1:0];
          up   <= 1'b1;
        end
      end
      sstt_pkg::S_SHIFT: begin
        if (src != last) begin
          src <= up ? (src - AW'(1)) : (src + AW'(1));
        end
      end
      sstt_pkg::S_DONE: begin
        if (out_free) begin
          out_data.status      <= req_oor ? sstt_pkg::ST_RANGE : res_status;
          out_data.read_value  <= req_oor ? '0 : res_value;
          out_data.entry_count <= cnt_ext[7:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule : sstt_back

`default_nettype wire

// ----- sv/sorted_sparse_triplet_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_sparse_triplet_table_top: sparse matrix triplet table
// Front end, request queue and table engine.
// ----------------------------------------------------------------------------
// Stores the nonzero elements of a sparse matrix as (row, column, value)
// entries in row-major order, up to CAPACITY entries, in a single-port-pair
// memory. Requests are taken into a two-entry queue, so the input is not
// stalled until that queue is full, even while a result waits at the output
// register. Each request scans back from the end of the table one entry at
// a time; a removal or insertion then moves the entries past the slot one
// at a time, as the table memory gives one read and one write each cycle.
// Out-of-range requests skip the scan and go straight to the result.
// The limit registers sit at byte addresses 0 (rows) and 4 (columns) and are
// to be written only while no request is in flight. No clearing pass is run
// after reset: only entries below the stored count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_sparse_triplet_table_top #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire                in_valid,
  output logic               in_stall,
  input  sstt_pkg::req_t     in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output sstt_pkg::rsp_t     out_data
);

  sstt_pkg::qpush_t qpush;
  sstt_pkg::qhead_t qhead;
  logic             q_full;
  logic             q_pop;

  // intake and classification
  sstt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .qpush    (qpush)
  );

  // request queue
  sstt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .qpush (qpush),
    .full  (q_full),
    .pop   (q_pop),
    .head  (qhead)
  );

  // table engine
  sstt_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (qhead),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule : sorted_sparse_triplet_table_top

`default_nettype wire

// ----- sv/sstt_checker.sv -----
// ----------------------------------------------------------------------------
// sstt_checker: port-level checks for the triplet table
// Watches the result channel of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sstt_checker #(
  parameter int unsigned CAPACITY = 128
) (
  input wire             clk,
  input wire             rst,
  input wire             out_valid,
  input wire             out_stall,
  input sstt_pkg::rsp_t  out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // nothing is shown right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // only a successful transfer carries a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != sstt_pkg::ST_OK |-> out_data.read_value == '0)
    else $error("value on a failed request");

  // the reported entry count never exceeds the capacity (checked up to 255)
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY > 255) || (32'(out_data.entry_count) <= CAPACITY))
    else $error("entry count above capacity");

  // a full report only when the count is at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == sstt_pkg::ST_FULL |->
      (CAPACITY > 255) || (32'(out_data.entry_count) == CAPACITY))
    else $error("full reported below capacity");

endmodule : sstt_checker

bind sorted_sparse_triplet_table_top sstt_checker #(
  .CAPACITY (CAPACITY)
) u_sstt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
